### src/rsx_pkg.sv
// Shared types, constants and tables for the radial sine transform.
package rsx_pkg;

  localparam int MAX_SAMPLES_DEF  = 2048;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int CORD_W           = 40;

  localparam logic [15:0]  GSTEP_RESET = 16'd131;
  localparam logic [63:0]  INV_TWO_PI  = 64'h28BE60DB9391054A;
  localparam logic [63:0]  HALF_PI_Q30 = 64'd1686629713;
  localparam logic [39:0]  CORDIC_GAIN = 40'd652032874;
  localparam logic [63:0]  W_LIMIT     = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0]  TERM_LIMIT  = 64'h0800_0000_0000_0000;
  localparam logic [63:0]  ACC_LIMIT   = 64'h2000_0000_0000_0000;
  localparam logic [30:0]  Q30_ONE     = 31'h4000_0000;

  // Reciprocals for division by a constant: quotient is the product shifted
  // right by 32 for six and 120, and by 65 for three.
  localparam logic [63:0]  RECIP_6     = 64'd715827883;
  localparam logic [63:0]  RECIP_120   = 64'd35791395;
  localparam logic [63:0]  RECIP_3     = 64'hAAAA_AAAA_AAAA_AAAB;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_EVAL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EVEN  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic {
    REG_G_STEP = 1'b0,
    REG_NONE   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [23:0]        radius;
    logic signed [31:0] density;
    logic [14:0]        g_index;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] transform_value;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  function automatic logic [30:0] atan_entry(input logic [5:0] idx);
    logic [30:0] res;
    res = '0;
    if (idx < 6'd10) begin
      unique case (idx)
        6'd0:    res = 31'd843314856;
        6'd1:    res = 31'd497837829;
        6'd2:    res = 31'd263043836;
        6'd3:    res = 31'd133525158;
        6'd4:    res = 31'd67021686;
        6'd5:    res = 31'd33543515;
        6'd6:    res = 31'd16775850;
        6'd7:    res = 31'd8388437;
        6'd8:    res = 31'd4194282;
        6'd9:    res = 31'd2097149;
        default: res = '0;
      endcase
    end else if (idx < 6'd30) begin
      res = (31'd1 << (6'd30 - idx)) - 31'd1;
    end
    return res;
  endfunction

endpackage

### src/rsx_mul.sv
// Shared 64 by 64 multiplier built from four 32 by 32 partial products.
module rsx_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  rsx_pkg::mul_req_t req,
  output rsx_pkg::mul_rsp_t rsp
);
  import rsx_pkg::*;

  logic [63:0]  a_r, b_r, pp_r;
  logic [127:0] acc_r, pp_ext;
  logic [1:0]   sh_r;
  logic [2:0]   cnt_r;
  logic         busy_r, done_r;
  logic [31:0]  ma, mb;

  assign ma = cnt_r[0] ? a_r[63:32] : a_r[31:0];
  assign mb = cnt_r[1] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    unique case (sh_r)
      2'd0:    pp_ext = {64'd0, pp_r};
      2'd1:    pp_ext = {32'd0, pp_r, 32'd0};
      2'd2:    pp_ext = {pp_r, 64'd0};
      default: pp_ext = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= req.a;
        b_r    <= req.b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r != 3'd4) begin
          pp_r <= 64'(ma) * 64'(mb);
          sh_r <= 2'(cnt_r[0]) + 2'(cnt_r[1]);
        end
        if (cnt_r != 3'd0) begin
          acc_r <= acc_r + pp_ext;
        end
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

### src/rsx_div.sv
// Shared restoring divider that resolves one quotient bit per cycle.
module rsx_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rsx_pkg::div_req_t req,
  output rsx_pkg::div_rsp_t rsp
);
  import rsx_pkg::*;

  logic [63:0] rem_r, quo_r, dsr_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [64:0] trial, diff;
  logic        ge;

  assign trial = {rem_r, quo_r[63]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dsr_r  <= req.divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[63:0] : trial[63:0];
        quo_r <= {quo_r[62:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

### src/radial_sine_transform.sv
// Top level: command sequencer, sample stores, CORDIC and register port.
//
//   channel   ports                               direction
//   command   start, busy, in_data                in
//   result    out_valid, out_data                 out
//   register  psel, penable, pwrite, paddr,       in/out
//             pwdata, prdata, pready
//
// A clear is done without leaving idle; a load makes two multiplier passes. An
// evaluate makes, per stored sample at large arguments, five multiplier passes,
// CORDIC_STEPS rotations and one divider pass; a small argument uses a series
// of multiplier passes instead. A count check comes first, a final scaling last.
// Reset clears the sample count, sets gstep to GSTEP_RESET; stores need no clearing.
// The result beat is shown for one cycle, and the receiver cannot stall it.
module radial_sine_transform #(
  parameter int MAX_SAMPLES  = rsx_pkg::MAX_SAMPLES_DEF,
  parameter int CORDIC_STEPS = rsx_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rsx_pkg::in_item_t  in_data,
  output logic               out_valid,
  output rsx_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rsx_pkg::*;

  localparam int IW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNTW = $clog2(MAX_SAMPLES + 1);
  localparam int CKW  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_RR, S_LD_W, S_EV_CHK, S_EV_RD, S_EV_DAT, S_EV_P, S_EV_X2,
    S_EV_X4, S_EV_D6, S_EV_D120, S_EV_TURN, S_EV_Z, S_EV_CORD, S_EV_QUAD,
    S_EV_SDIV, S_EV_M1, S_EV_M2, S_EV_FIN
  } state_t;

  state_t state_r;
  logic   pend_r;

  logic [CNTW-1:0]       cnt_r, idx_r;
  logic [15:0]           gstep_r;
  logic [14:0]           gidx_r;
  logic [30:0]           g_r;
  logic [23:0]           r_r, prev_r;
  logic [31:0]           dmag_r;
  logic                  dneg_r;
  logic [47:0]           rr_r;
  logic signed [47:0]    w_r;
  logic signed [24:0]    dr_r;
  logic [54:0]           p_r;
  logic [22:0]           x2_r, q6_r;
  logic [14:0]           x4_r;
  logic [1:0]            qq_r;
  logic                  tneg_r;
  logic [29:0]           tmag_r;
  logic signed [CORD_W-1:0] cx_r, cy_r, cz_r;
  logic [CKW-1:0]        ck_r;
  logic [30:0]           smag_r, sc_mag_r;
  logic                  sc_neg_r;
  logic [59:0]           m1_r;
  logic signed [63:0]    acc_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic [23:0]        rad_mem [MAX_SAMPLES];
  logic signed [47:0] wd_mem  [MAX_SAMPLES];
  logic [23:0]        rad_rd_r;
  logic signed [47:0] wd_rd_r;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     mul_op, div_op, op_done, mem_we, cfg_wr;

  function automatic logic [63:0] mul_shr(input logic [127:0] prod, input logic [6:0] s,
                                          input logic [63:0] lim);
    logic [127:0] full, sh;
    full = prod + (128'd1 << (s - 7'd1));
    sh   = full >> s;
    if (sh > {64'd0, lim}) begin
      return lim;
    end
    return sh[63:0];
  endfunction

  rsx_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  rsx_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  always_comb begin
    mul_req = '0;
    div_req = '0;
    mul_op  = 1'b0;
    div_op  = 1'b0;
    unique case (state_r)
      S_LD_RR: begin
        mul_op = 1'b1; mul_req.a = 64'(r_r); mul_req.b = 64'(r_r);
      end
      S_LD_W: begin
        mul_op = 1'b1; mul_req.a = 64'(dmag_r); mul_req.b = 64'(rr_r);
      end
      S_EV_P: begin
        mul_op = 1'b1; mul_req.a = 64'(g_r); mul_req.b = 64'(r_r);
      end
      S_EV_X2: begin
        mul_op = 1'b1; mul_req.a = 64'(p_r); mul_req.b = 64'(p_r);
      end
      S_EV_X4: begin
        mul_op = 1'b1; mul_req.a = 64'(x2_r); mul_req.b = 64'(x2_r);
      end
      S_EV_TURN: begin
        mul_op = 1'b1; mul_req.a = 64'(p_r); mul_req.b = INV_TWO_PI;
      end
      S_EV_Z: begin
        mul_op = 1'b1; mul_req.a = 64'(tmag_r); mul_req.b = HALF_PI_Q30;
      end
      S_EV_M1: begin
        mul_op = 1'b1;
        mul_req.a = 64'(w_r[47] ? -w_r : w_r);
        mul_req.b = 64'(sc_mag_r);
      end
      S_EV_M2: begin
        mul_op = 1'b1; mul_req.a = 64'(m1_r);
        mul_req.b = 64'(dr_r[24] ? -dr_r : dr_r);
      end
      S_EV_D6: begin
        mul_op = 1'b1; mul_req.a = 64'(x2_r); mul_req.b = RECIP_6;
      end
      S_EV_D120: begin
        mul_op = 1'b1; mul_req.a = 64'(x4_r); mul_req.b = RECIP_120;
      end
      S_EV_SDIV: begin
        div_op = 1'b1;
        div_req.dividend = {1'b0, smag_r, 32'd0} + 64'(p_r[54:1]);
        div_req.divisor  = 64'(p_r);
      end
      S_EV_FIN: begin
        mul_op = 1'b1;
        mul_req.a = (acc_r[63] ? 64'(-acc_r) : 64'(acc_r)) + 64'd1;
        mul_req.b = RECIP_3;
      end
      default: ;
    endcase
    mul_req.start = mul_op & ~pend_r;
    div_req.start = div_op & ~pend_r;
    op_done = pend_r & ((mul_op & mul_rsp.done) | (div_op & div_rsp.done));
  end

  logic [63:0]            w_mag_new, m_sh22, m_sh16, term, q_fin, q3;
  logic signed [47:0]     w_new;
  logic [22:0]            x2_new;
  logic [14:0]            x4_new;
  logic [31:0]            t_new;
  logic [32:0]            tq;
  logic signed [33:0]     tres;
  logic [28:0]            z_new;
  logic signed [CORD_W-1:0] dx, dy, da, s_val;
  logic [CORD_W-1:0]      s_abs;
  logic                   term_neg, is_first, is_last;
  logic signed [63:0]     acc_sum;
  logic signed [24:0]     dr_new;

  always_comb begin
    w_mag_new = mul_shr(mul_rsp.prod, 7'd32, W_LIMIT);
    w_new     = dneg_r ? -$signed(w_mag_new[47:0]) : $signed(w_mag_new[47:0]);
    m_sh22    = mul_shr(mul_rsp.prod, 7'd22, TERM_LIMIT);
    m_sh16    = mul_shr(mul_rsp.prod, 7'd16, TERM_LIMIT);
    x2_new    = 23'((mul_rsp.prod + (128'd1 << 33)) >> 34);
    x4_new    = 15'((mul_rsp.prod + (128'd1 << 29)) >> 30);
    z_new     = 29'((mul_rsp.prod + (128'd1 << 31)) >> 32);
    t_new     = mul_rsp.prod[95:64];
    tq        = {1'b0, t_new} + 33'h0_2000_0000;
    tres      = $signed({2'b00, t_new}) - $signed({1'b0, tq[32:30], 30'd0});

    dx = cy_r >>> ck_r;
    dy = cx_r >>> ck_r;
    da = $signed({{(CORD_W-31){1'b0}}, atan_entry(6'(ck_r))});

    unique case (qq_r)
      2'd0:    s_val = cy_r;
      2'd1:    s_val = cx_r;
      2'd2:    s_val = -cy_r;
      default: s_val = -cx_r;
    endcase
    s_abs = s_val[CORD_W-1] ? CORD_W'(-s_val) : CORD_W'(s_val);

    dr_new = $signed({1'b0, rad_rd_r}) -
             $signed({1'b0, (idx_r == '0) ? 24'd0 : prev_r});

    is_first = idx_r == '0;
    is_last  = idx_r == cnt_r - CNTW'(1);
    if (is_first || is_last) begin
      term = m_sh16;
    end else if (idx_r[0]) begin
      term = m_sh16 << 2;
    end else begin
      term = m_sh16 << 1;
    end
    term_neg = w_r[47] ^ sc_neg_r ^ dr_r[24];
    acc_sum  = term_neg ? acc_r - $signed(term) : acc_r + $signed(term);
    q_fin    = div_rsp.quot;
    q3       = {1'b0, mul_rsp.prod[127:65]};
  end

  assign mem_we = (state_r == S_LD_W) && op_done;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rad_mem[cnt_r[IW-1:0]] <= r_r;
      wd_mem[cnt_r[IW-1:0]]  <= w_new;
    end
    rad_rd_r <= rad_mem[idx_r[IW-1:0]];
    wd_rd_r  <= wd_mem[idx_r[IW-1:0]];
  end

  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_G_STEP) ? {16'd0, gstep_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gstep_r <= GSTEP_RESET;
    end else if (cfg_wr && paddr[2] == REG_G_STEP) begin
      gstep_r <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (mul_req.start || div_req.start) begin
        pend_r <= 1'b1;
      end else if (op_done) begin
        pend_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            r_r    <= in_data.radius;
            dneg_r <= in_data.density[31];
            dmag_r <= in_data.density[31] ? 32'(-in_data.density) : 32'(in_data.density);
            gidx_r <= in_data.g_index;
            if (in_data.command == CMD_CLEAR) begin
              cnt_r <= '0;
            end else if (in_data.command == CMD_LOAD) begin
              if (cnt_r < CNTW'(MAX_SAMPLES)) begin
                state_r <= S_LD_RR;
              end
            end else if (in_data.command == CMD_EVAL) begin
              state_r <= S_EV_CHK;
            end
          end
        end
        S_LD_RR: begin
          if (op_done) begin
            rr_r    <= mul_rsp.prod[47:0];
            state_r <= S_LD_W;
          end
        end
        S_LD_W: begin
          if (op_done) begin
            cnt_r   <= cnt_r + CNTW'(1);
            state_r <= S_IDLE;
          end
        end
        S_EV_CHK: begin
          g_r   <= 31'(gidx_r) * 31'(gstep_r);
          idx_r <= '0;
          acc_r <= '0;
          if (cnt_r == '0 || !cnt_r[0]) begin
            out_valid_r                <= 1'b1;
            out_data_r.transform_value <= '0;
            out_data_r.status          <= (cnt_r == '0) ? ST_EMPTY : ST_EVEN;
            state_r                    <= S_IDLE;
          end else begin
            state_r <= S_EV_RD;
          end
        end
        S_EV_RD: begin
          state_r <= S_EV_DAT;
        end
        S_EV_DAT: begin
          r_r     <= rad_rd_r;
          w_r     <= wd_rd_r;
          dr_r    <= dr_new;
          state_r <= S_EV_P;
        end
        S_EV_P: begin
          if (op_done) begin
            p_r     <= mul_rsp.prod[54:0];
            state_r <= (mul_rsp.prod[54:28] == '0) ? S_EV_X2 : S_EV_TURN;
          end
        end
        S_EV_X2: begin
          if (op_done) begin
            x2_r    <= x2_new;
            state_r <= S_EV_X4;
          end
        end
        S_EV_X4: begin
          if (op_done) begin
            x4_r    <= x4_new;
            state_r <= S_EV_D6;
          end
        end
        S_EV_D6: begin
          if (op_done) begin
            q6_r    <= mul_rsp.prod[54:32];
            state_r <= S_EV_D120;
          end
        end
        S_EV_D120: begin
          if (op_done) begin
            sc_mag_r <= Q30_ONE - 31'(q6_r) + 31'(mul_rsp.prod[46:32]);
            sc_neg_r <= 1'b0;
            state_r  <= S_EV_M1;
          end
        end
        S_EV_TURN: begin
          if (op_done) begin
            qq_r    <= tq[31:30];
            tneg_r  <= tres[33];
            tmag_r  <= tres[33] ? 30'(-tres) : 30'(tres);
            state_r <= S_EV_Z;
          end
        end
        S_EV_Z: begin
          if (op_done) begin
            cx_r    <= CORDIC_GAIN;
            cy_r    <= '0;
            cz_r    <= tneg_r ? -$signed(CORD_W'(z_new)) : $signed(CORD_W'(z_new));
            ck_r    <= '0;
            state_r <= S_EV_CORD;
          end
        end
        S_EV_CORD: begin
          if (!cz_r[CORD_W-1]) begin
            cx_r <= cx_r - dx;
            cy_r <= cy_r + dy;
            cz_r <= cz_r - da;
          end else begin
            cx_r <= cx_r + dx;
            cy_r <= cy_r - dy;
            cz_r <= cz_r + da;
          end
          ck_r <= ck_r + CKW'(1);
          if (ck_r == CKW'(CORDIC_STEPS - 1)) begin
            state_r <= S_EV_QUAD;
          end
        end
        S_EV_QUAD: begin
          smag_r   <= (s_abs > CORD_W'(Q30_ONE)) ? Q30_ONE : s_abs[30:0];
          sc_neg_r <= s_val[CORD_W-1];
          state_r  <= S_EV_SDIV;
        end
        S_EV_SDIV: begin
          if (op_done) begin
            sc_mag_r <= (q_fin > 64'(Q30_ONE)) ? Q30_ONE : q_fin[30:0];
            state_r  <= S_EV_M1;
          end
        end
        S_EV_M1: begin
          if (op_done) begin
            m1_r    <= m_sh22[59:0];
            state_r <= S_EV_M2;
          end
        end
        S_EV_M2: begin
          if (op_done) begin
            if (acc_sum > $signed(ACC_LIMIT)) begin
              acc_r <= $signed(ACC_LIMIT);
            end else if (acc_sum < -$signed(ACC_LIMIT)) begin
              acc_r <= -$signed(ACC_LIMIT);
            end else begin
              acc_r <= acc_sum;
            end
            prev_r <= r_r;
            idx_r  <= idx_r + CNTW'(1);
            state_r <= is_last ? S_EV_FIN : S_EV_RD;
          end
        end
        S_EV_FIN: begin
          if (op_done) begin
            out_valid_r       <= 1'b1;
            out_data_r.status <= ST_OK;
            if (!acc_r[63]) begin
              if (q3 > W_LIMIT) begin
                out_data_r.transform_value <= $signed(W_LIMIT[47:0]);
                out_data_r.status          <= ST_SAT;
              end else begin
                out_data_r.transform_value <= $signed(q3[47:0]);
              end
            end else begin
              if (q3 > W_LIMIT + 64'd1) begin
                out_data_r.transform_value <= -$signed(W_LIMIT[47:0]) - 48'sd1;
                out_data_r.status          <= ST_SAT;
              end else begin
                out_data_r.transform_value <= -$signed(q3[47:0]);
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result beat while the sequencer is busy");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(MAX_SAMPLES)) else $error("sample count beyond the store depth");

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_req.start && div_req.start)) else $error("two units started together");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.command == CMD_EVAL) |=> busy)
    else $error("evaluate command did not start the sequencer");

endmodule

### test/radial_sine_transform_tb.sv
// Self-checking testbench for the radial sine transform.
`timescale 1ns / 100ps

module radial_sine_transform_tb;
  import rsx_pkg::*;

  localparam int DEPTH       = 2048;
  localparam int STALL_LIMIT = 60000;
  localparam int SETTLE      = 40;
  localparam int RANDOM_BEATS = 250;
  localparam logic [63:0] TURN_RECIP  = 64'h28BE60DB9391054A;
  localparam logic [63:0] QUARTER_RAD = 64'd1686629713;
  localparam logic [63:0] WEIGHT_MAX  = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] TERM_MAX    = 64'h0800_0000_0000_0000;
  localparam longint      SUM_MAX     = 64'sh2000_0000_0000_0000;
  localparam longint      UNITY       = 64'sd1073741824;
  localparam longint      ROT_GAIN    = 64'sd652032874;
  localparam longint      ARC_HEAD [10] = '{843314856, 497837829, 263043836, 133525158,
                                            67021686, 33543515, 16775850, 8388437,
                                            4194282, 2097149};

  typedef struct {
    bit        is_write;
    in_item_t  item;
    bit [15:0] step;
  } pending_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pending_t  pending_q[$];
  out_item_t transform_q[$];

  bit [23:0]   radius_mem [DEPTH];
  longint      weight_mem [DEPTH];
  int unsigned loaded = 0;
  bit [15:0]   step_now = GSTEP_RESET;

  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int writes_done = 0;
  int gap = 0;
  bit burst = 1'b0;
  int quiet = 0;
  int stall = 0;

  radial_sine_transform u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit [63:0] round_mul(bit [63:0] a, bit [63:0] b, int s, bit [63:0] lim);
    bit [127:0] p;
    bit [127:0] q;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (s - 1));
    q = p >> s;
    if (q[127:64] != 0) return lim;
    return (q[63:0] > lim) ? lim : q[63:0];
  endfunction

  function automatic longint arc_step(int i);
    if (i < 10) return ARC_HEAD[i];
    if (i < 30) return (64'sd1 << (30 - i)) - 1;
    return 0;
  endfunction

  function automatic longint turn_sine(bit [63:0] t);
    bit [63:0] qq;
    bit [63:0] mag;
    longint res, z, x, y, dx, dy, da;
    qq  = (t + (64'd1 << 29)) >> 30;
    res = longint'(t) - longint'(qq << 30);
    mag = (res < 0) ? 64'(-res) : 64'(res);
    z = longint'((mag * QUARTER_RAD + (64'd1 << 31)) >> 32);
    x = ROT_GAIN;
    y = 0;
    if (res < 0) z = -z;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      da = arc_step(i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= da;
      end else begin
        x += dx; y -= dy; z += da;
      end
    end
    case (qq[1:0])
      2'd0: return y;
      2'd1: return x;
      2'd2: return -y;
      default: return -x;
    endcase
  endfunction

  function automatic longint sinc_of(bit [63:0] p);
    bit [63:0]  x2, x4, mag, q;
    bit [127:0] prod;
    longint     s;
    if (p < (64'd1 << 28)) begin
      x2 = (p * p + (64'd1 << 33)) >> 34;
      x4 = (x2 * x2 + (64'd1 << 29)) >> 30;
      return UNITY - longint'(x2 / 6) + longint'(x4 / 120);
    end
    prod = {64'd0, p} * {64'd0, TURN_RECIP};
    s = turn_sine({32'd0, prod[95:64]});
    mag = (s < 0) ? 64'(-s) : 64'(s);
    if (mag > 64'(UNITY)) mag = 64'(UNITY);
    q = ((mag << 32) + p / 2) / p;
    if (q > 64'(UNITY)) q = 64'(UNITY);
    return (s < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic out_item_t transform_at(bit [14:0] gi);
    out_item_t  res;
    bit [63:0]  g, r, m1, m2, mag, q;
    longint     w, sc, dr, coef, term, acc;
    bit         neg;
    res = '0;
    acc = 0;
    g = 64'(gi) * 64'(step_now);
    if (loaded == 0 || loaded[0] == 1'b0) begin
      res.status = (loaded == 0) ? ST_EMPTY : ST_EVEN;
      return res;
    end
    for (int i = 0; i < loaded; i++) begin
      r  = 64'(radius_mem[i]);
      w  = weight_mem[i];
      sc = sinc_of(g * r);
      dr = (i == 0) ? longint'(r) : longint'(r) - longint'(radius_mem[i-1]);
      m1 = round_mul((w < 0) ? 64'(-w) : 64'(w), (sc < 0) ? 64'(-sc) : 64'(sc), 22, TERM_MAX);
      m2 = round_mul(m1, (dr < 0) ? 64'(-dr) : 64'(dr), 16, TERM_MAX);
      coef = (i == 0 || i == loaded - 1) ? 1 : ((i % 2 == 1) ? 4 : 2);
      term = coef * longint'(m2);
      neg = (w < 0) != (sc < 0);
      if (dr < 0) neg = !neg;
      acc += neg ? -term : term;
      if (acc > SUM_MAX) acc = SUM_MAX;
      if (acc < -SUM_MAX) acc = -SUM_MAX;
    end
    mag = (acc < 0) ? 64'(-acc) : 64'(acc);
    q = (mag + 1) / 3;
    res.status = ST_OK;
    if (acc >= 0) begin
      if (q > WEIGHT_MAX) begin
        q = WEIGHT_MAX; res.status = ST_SAT;
      end
      res.transform_value = q[47:0];
    end else begin
      if (q > WEIGHT_MAX + 1) begin
        q = WEIGHT_MAX + 1; res.status = ST_SAT;
      end
      res.transform_value = -q[47:0];
    end
    return res;
  endfunction

  task automatic apply_command(in_item_t it);
    bit [63:0] dmag, wmag;
    longint    d;
    case (cmd_t'(it.command))
      CMD_CLEAR: loaded = 0;
      CMD_LOAD: begin
        if (loaded < DEPTH) begin
          d = longint'(it.density);
          dmag = (d < 0) ? 64'(-d) : 64'(d);
          wmag = round_mul(dmag, 64'(it.radius) * 64'(it.radius), 32, WEIGHT_MAX);
          radius_mem[loaded] = it.radius;
          weight_mem[loaded] = (d < 0) ? -longint'(wmag) : longint'(wmag);
          loaded++;
        end
      end
      CMD_EVAL: transform_q.push_back(transform_at(it.g_index));
      default: ;
    endcase
  endtask

  task automatic report(string what, out_item_t got, out_item_t want);
    $display("%0t mismatch (%s): value %h status %0d, expected value %h status %0d",
             $time, what, got.transform_value, got.status, want.transform_value, want.status);
    errors++;
  endtask

  task automatic push_cmd(cmd_t c, bit [23:0] r, bit [31:0] d, bit [14:0] gi);
    pending_t p;
    p.is_write = 1'b0;
    p.item.command = c;
    p.item.radius  = r;
    p.item.density = d;
    p.item.g_index = gi;
    p.step = '0;
    pending_q.push_back(p);
  endtask

  task automatic push_step(bit [15:0] v);
    pending_t p;
    p.is_write = 1'b1;
    p.item = '0;
    p.step = v;
    pending_q.push_back(p);
  endtask

  // Driver: command beats and register writes from the pending queue.
  always @(posedge clk) begin
    pending_t nxt;
    int       g;
    if (!rst_n) begin
      start <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
    end else if (start && !busy) begin
      apply_command(in_data);
      beats_in++;
      if ($urandom_range(0, 31) == 0) burst = !burst;
      g = burst ? 0 : $urandom_range(0, 16);
      if (g == 0 && pending_q.size() != 0 && !pending_q[0].is_write) begin
        nxt = pending_q.pop_front();
        in_data <= nxt.item;
      end else begin
        start <= 1'b0;
        gap <= g;
      end
    end else if (start) begin
    end else if (psel && penable) begin
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      step_now = pwdata[15:0];
      writes_done++;
    end else if (psel) begin
      penable <= 1'b1;
    end else if (gap != 0) begin
      gap <= gap - 1;
    end else if (pending_q.size() != 0) begin
      if (pending_q[0].is_write) begin
        if (transform_q.size() == 0 && !busy && quiet >= SETTLE) begin
          nxt = pending_q.pop_front();
          psel <= 1'b1;
          pwrite <= 1'b1;
          paddr <= 3'(REG_G_STEP) << 2;
          pwdata <= {16'd0, nxt.step};
        end
      end else begin
        nxt = pending_q.pop_front();
        in_data <= nxt.item;
        start <= 1'b1;
      end
    end
  end

  // Monitor: every result beat against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      beats_out++;
      if (transform_q.size() == 0) begin
        report("unexpected beat", out_data, '0);
      end else begin
        want = transform_q.pop_front();
        if (out_data.transform_value != want.transform_value)
          report("transform_value", out_data, want);
        else if (out_data.status != want.status)
          report("status", out_data, want);
      end
    end
  end

  always @(posedge clk) begin
    if (busy || out_valid || start || psel) quiet <= 0;
    else if (quiet < 1000) quiet <= quiet + 1;
    if ((start && !busy) || out_valid || (psel && penable)) stall <= 0;
    else stall <= stall + 1;
    if (rst_n && stall >= STALL_LIMIT) begin
      $display("timeout with %0d beats pending", transform_q.size());
      $display("radial_sine_transform_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int          made, k, evals;
    bit [23:0]   r;
    bit [14:0]   gi;
    bit [15:0]   steps [6];
    bit [95:0]   raw;
    pending_t    junk;

    push_cmd(CMD_EVAL, 0, 0, 0);
    push_cmd(CMD_LOAD, 24'h000000, 32'h7FFF_FFFF, 0);
    push_cmd(CMD_EVAL, 0, 0, 15'h7FFF);
    push_cmd(CMD_LOAD, 24'hFFFFFF, 32'h8000_0000, 0);
    push_cmd(CMD_EVAL, 0, 0, 0);
    push_cmd(CMD_LOAD, 24'h800000, 32'hFFFF_FFFF, 0);
    push_cmd(CMD_EVAL, 0, 0, 0);
    push_cmd(CMD_EVAL, 24'hFFFFFF, 32'hFFFF_FFFF, 15'h7FFF);
    push_cmd(CMD_EVAL, 0, 0, 1);
    push_cmd(CMD_NONE, 24'hFFFFFF, 32'hFFFF_FFFF, 15'h7FFF);
    push_cmd(CMD_LOAD, 24'h010000, 32'h7FFF_FFFF, 0);
    push_cmd(CMD_LOAD, 24'hFFFFFF, 32'h7FFF_FFFF, 0);
    push_cmd(CMD_EVAL, 0, 0, 0);
    push_step(16'd0);
    push_cmd(CMD_EVAL, 0, 0, 15'h7FFF);
    push_step(16'hFFFF);
    push_cmd(CMD_EVAL, 0, 0, 15'h7FFF);
    push_cmd(CMD_EVAL, 0, 0, 15'h0001);
    push_cmd(CMD_CLEAR, 0, 0, 0);
    push_cmd(CMD_EVAL, 0, 0, 0);
    push_step(GSTEP_RESET);

    steps = '{16'd1, 16'hFFFF, 16'(GSTEP_RESET), 16'd0, 16'(0), 16'(0)};
    made = 0;
    for (int ph = 0; made < RANDOM_BEATS; ph++) begin
      push_step((ph < 4) ? steps[ph] : 16'($urandom_range(1, 65535)));
      for (int s = 0; s < 4 && made < RANDOM_BEATS; s++) begin
        if ($urandom_range(0, 9) == 0) begin
          raw = {$urandom, $urandom, $urandom};
          junk.item = in_item_t'(raw[$bits(in_item_t)-1:0]);
          push_cmd(cmd_t'(junk.item.command), junk.item.radius, junk.item.density,
                   junk.item.g_index);
          made++;
        end
        push_cmd(CMD_CLEAR, 0, 0, 0);
        k = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : 2 * $urandom_range(0, 10) + 1;
        r = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4096));
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 7) == 0) r = 24'($urandom);
          else r = r + 24'($urandom_range(0, 65536));
          push_cmd(CMD_LOAD, r,
                   ($urandom_range(0, 1) != 0) ? $urandom
                     : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)),
                   0);
        end
        evals = $urandom_range(1, 4);
        for (int e = 0; e < evals; e++) begin
          case ($urandom_range(0, 2))
            0: gi = 15'($urandom_range(0, 40));
            1: gi = 15'($urandom_range(0, 2000));
            default: gi = 15'($urandom);
          endcase
          push_cmd(CMD_EVAL, 24'($urandom), $urandom, gi);
        end
        made += k + evals + 1;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || start || psel || transform_q.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    while (transform_q.size() != 0) begin
      report("missing beat", '0, transform_q.pop_front());
    end

    $display("%0d command beats, %0d result beats, %0d step writes", beats_in, beats_out,
             writes_done);
    $display("covered empty, even, saturating and random sample sets under step changes");
    if (errors == 0) begin
      $display("radial_sine_transform_tb OK");
    end else begin
      $display("radial_sine_transform_tb NOT OK");
    end
    $finish;
  end

endmodule
